[rtl/core/strq_pkg.sv]
// types and codes shared by the track-grouping request queue
package strq_pkg;

  typedef enum logic [0:0] {
    CMD_ADD  = 1'b0,
    CMD_TAKE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_ALLOC,
    ST_PLACE,
    ST_WALK,
    ST_LINK
  } state_t;

  localparam int unsigned TRACK_W = 12;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned COUNT_W = 6;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [TAG_W-1:0]   tag;
    logic [SEQ_W-1:0]   seq;
  } entry_t;

endpackage

[rtl/core/same_track_request_queue_top.sv]
// track-grouping disk request queue: linked list held in a data memory and a link memory
// flow: a rejected item (take on empty, add on full) gives its result straight from idle.
// a take passes through TAKE; an add to the front or into an empty queue through PLACE,
// after ALLOC when the node comes off the free list. any other add walks the list one node
// per cycle through the link memory in WALK, then ends in LINK; busy is high meanwhile.
// one item at a time; the receiver cannot stall, each result is a one-cycle out_valid strobe.
// synchronous active-low reset empties the queue and clears the sequence counter.
module same_track_request_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [strq_pkg::TRACK_W-1:0] in_req_track,
  input  logic [strq_pkg::TAG_W-1:0]   in_req_tag,
  input  logic [strq_pkg::TRACK_W-1:0] in_head_track,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [strq_pkg::TRACK_W-1:0] out_track,
  output logic [strq_pkg::TAG_W-1:0]   out_tag,
  output logic [strq_pkg::SEQ_W-1:0]   out_sequence,
  output logic [strq_pkg::COUNT_W-1:0] out_queue_count
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > strq_pkg::COUNT_W) ? CNT_W : strq_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // node storage: payload and forward link, same address space
  strq_pkg::entry_t data_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] link_mem [QUEUE_DEPTH];

  // memory ports
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  strq_pkg::entry_t mem_rd_data_r;
  logic [PTR_W-1:0] mem_rd_link_r;
  logic             dwr_en;
  logic [PTR_W-1:0] dwr_addr;
  strq_pkg::entry_t dwr_data;
  logic             lwr_en;
  logic [PTR_W-1:0] lwr_addr;
  logic [PTR_W-1:0] lwr_data;

  // control state
  strq_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  // nodes below fill_r have been handed out at least once; once all have, nodes come off the free list
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [strq_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] free_r, free_nxt;

  // per-item working registers
  logic [PTR_W-1:0] new_r, new_nxt;
  logic [PTR_W-1:0] cur_r, cur_nxt;
  logic [PTR_W-1:0] prev_r, prev_nxt;
  logic             match_r, match_nxt;
  logic [PTR_W-1:0] q_r, q_nxt;
  logic [strq_pkg::TRACK_W-1:0] trk_r, trk_nxt;
  logic [strq_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [strq_pkg::TRACK_W-1:0] htrk_r, htrk_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [strq_pkg::TRACK_W-1:0] out_track_r, out_track_nxt;
  logic [strq_pkg::TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic [strq_pkg::SEQ_W-1:0]   out_seq_r, out_seq_nxt;

  logic accept;
  logic is_take;
  logic is_empty;
  logic is_full;
  logic from_fill;
  logic run_ends;     // previous node matched the track, this one does not
  logic at_tail;
  logic [EXT_W-1:0] count_ext;

  assign accept    = start && !busy;
  assign is_take   = (in_command == strq_pkg::CMD_TAKE);
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == DEPTH_C);
  assign from_fill = (fill_r < DEPTH_C);
  assign run_ends  = match_r && (mem_rd_data_r.track != trk_r);
  assign at_tail   = (cur_r == tail_r);

  // memories: one read port with registered data, one write port each
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_rd_data_r <= data_mem[rd_addr];
      mem_rd_link_r <= link_mem[rd_addr];
    end
    if (dwr_en) begin
      data_mem[dwr_addr] <= dwr_data;
    end
    if (lwr_en) begin
      link_mem[lwr_addr] <= lwr_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      strq_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_take) begin
            if (!is_empty) state_nxt = strq_pkg::ST_TAKE;
          end else if (!is_full) begin
            state_nxt = from_fill ? strq_pkg::ST_PLACE : strq_pkg::ST_ALLOC;
          end
        end
      end
      strq_pkg::ST_TAKE:  state_nxt = strq_pkg::ST_IDLE;
      strq_pkg::ST_ALLOC: state_nxt = strq_pkg::ST_PLACE;
      strq_pkg::ST_PLACE: begin
        if (is_empty || trk_r == htrk_r) state_nxt = strq_pkg::ST_IDLE;
        else                             state_nxt = strq_pkg::ST_WALK;
      end
      strq_pkg::ST_WALK: begin
        if (run_ends || at_tail) state_nxt = strq_pkg::ST_LINK;
      end
      strq_pkg::ST_LINK:  state_nxt = strq_pkg::ST_IDLE;
      default:            state_nxt = strq_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    count_nxt = count_r;
    fill_nxt  = fill_r;
    seq_nxt   = seq_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    new_nxt   = new_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    match_nxt = match_r;
    q_nxt     = q_r;
    trk_nxt   = trk_r;
    tag_nxt   = tag_r;
    htrk_nxt  = htrk_r;

    rd_en    = 1'b0;
    rd_addr  = head_r;
    dwr_en   = 1'b0;
    dwr_addr = new_r;
    dwr_data = '{track: trk_r, tag: tag_r, seq: seq_r};
    lwr_en   = 1'b0;
    lwr_addr = new_r;
    lwr_data = head_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = strq_pkg::STAT_OK;
    out_track_nxt  = '0;
    out_tag_nxt    = tag_r;
    out_seq_nxt    = seq_r;

    case (state_r)
      strq_pkg::ST_IDLE: begin
        if (accept) begin
          trk_nxt  = in_req_track;
          tag_nxt  = in_req_tag;
          htrk_nxt = in_head_track;
          if (is_take) begin
            if (is_empty) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = strq_pkg::STAT_EMPTY;
              out_tag_nxt    = '0;
              out_seq_nxt    = '0;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_r;
            end
          end else if (is_full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = strq_pkg::STAT_FULL;
            out_tag_nxt    = '0;
            out_seq_nxt    = '0;
          end else begin
            seq_nxt = seq_r + 1'b1;
            if (from_fill) begin
              new_nxt  = fill_r[PTR_W-1:0];
              fill_nxt = fill_r + 1'b1;
            end else begin
              // pop the free list: its next link arrives next cycle
              new_nxt = free_r;
              rd_en   = 1'b1;
              rd_addr = free_r;
            end
          end
        end
      end

      strq_pkg::ST_TAKE: begin
        // release the front node onto the free list
        out_valid_nxt = 1'b1;
        out_track_nxt = mem_rd_data_r.track;
        out_tag_nxt   = mem_rd_data_r.tag;
        out_seq_nxt   = mem_rd_data_r.seq;
        head_nxt      = mem_rd_link_r;
        lwr_en        = 1'b1;
        lwr_addr      = head_r;
        lwr_data      = free_r;
        free_nxt      = head_r;
        count_nxt     = count_r - 1'b1;
      end

      strq_pkg::ST_ALLOC: begin
        free_nxt = mem_rd_link_r;
      end

      strq_pkg::ST_PLACE: begin
        if (is_empty) begin
          dwr_en        = 1'b1;
          head_nxt      = new_r;
          tail_nxt      = new_r;
          count_nxt     = count_r + 1'b1;
          out_valid_nxt = 1'b1;
        end else if (trk_r == htrk_r) begin
          // head is on this track: new front entry
          dwr_en        = 1'b1;
          lwr_en        = 1'b1;
          lwr_addr      = new_r;
          lwr_data      = head_r;
          head_nxt      = new_r;
          count_nxt     = count_r + 1'b1;
          out_valid_nxt = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          cur_nxt   = head_r;
          match_nxt = 1'b0;
        end
      end

      strq_pkg::ST_WALK: begin
        if (run_ends) begin
          // end of the first matching run: insert between prev and cur
          dwr_en   = 1'b1;
          lwr_en   = 1'b1;
          lwr_addr = new_r;
          lwr_data = cur_r;
          q_nxt    = prev_r;
        end else if (at_tail) begin
          // tail reached: either the run ends here or no run exists, append
          dwr_en   = 1'b1;
          q_nxt    = cur_r;
          tail_nxt = new_r;
        end else begin
          match_nxt = (mem_rd_data_r.track == trk_r);
          prev_nxt  = cur_r;
          cur_nxt   = mem_rd_link_r;
          rd_en     = 1'b1;
          rd_addr   = mem_rd_link_r;
        end
      end

      strq_pkg::ST_LINK: begin
        lwr_en        = 1'b1;
        lwr_addr      = q_r;
        lwr_data      = new_r;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strq_pkg::ST_IDLE;
      count_r     <= '0;
      fill_r      <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pointers and payload: only meaningful once the counts say so
  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    free_r       <= free_nxt;
    new_r        <= new_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    match_r      <= match_nxt;
    q_r          <= q_nxt;
    trk_r        <= trk_nxt;
    tag_r        <= tag_nxt;
    htrk_r       <= htrk_nxt;
    out_status_r <= out_status_nxt;
    out_track_r  <= out_track_nxt;
    out_tag_r    <= out_tag_nxt;
    out_seq_r    <= out_seq_nxt;
  end

  // count is updated at the same edge the strobe rises, so it is current during the strobe
  assign count_ext       = EXT_W'(count_r);
  assign busy            = (state_r != strq_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_track       = out_track_r;
  assign out_tag         = out_tag_r;
  assign out_sequence    = out_seq_r;
  assign out_queue_count = count_ext[strq_pkg::COUNT_W-1:0];

  // occupancy never exceeds the node pool
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= DEPTH_C)
    else $error("queue occupancy above depth");

  // every live node has been handed out at least once
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= fill_r)
    else $error("occupancy exceeds allocated nodes");

  // a result only follows an accepted item or the end of a multi-cycle operation
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept) || $past(state_r != strq_pkg::ST_IDLE))
    else $error("result strobe without an item");

  // the list walk and a take only run on a non-empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == strq_pkg::ST_WALK || state_r == strq_pkg::ST_TAKE) |-> !is_empty)
    else $error("list access on empty queue");

  // no start is taken while an item is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != strq_pkg::ST_IDLE) |=> $stable(seq_r) || $past(state_r == strq_pkg::ST_IDLE))
    else $error("sequence counter moved mid-item");

endmodule

[tb/sv/strq_checker.sv]
// checker for the track-grouping request queue: tracks the queue, predicts each result, compares
module strq_checker #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         in_command,
  input  logic [strq_pkg::TRACK_W-1:0] in_req_track,
  input  logic [strq_pkg::TAG_W-1:0]   in_req_tag,
  input  logic [strq_pkg::TRACK_W-1:0] in_head_track,
  input  logic                         out_valid,
  input  logic [1:0]                   out_status,
  input  logic [strq_pkg::TRACK_W-1:0] out_track,
  input  logic [strq_pkg::TAG_W-1:0]   out_tag,
  input  logic [strq_pkg::SEQ_W-1:0]   out_sequence,
  input  logic [strq_pkg::COUNT_W-1:0] out_queue_count,
  output int                           fail_count,
  output int                           results_due
);

  typedef struct packed {
    strq_pkg::status_t            status;
    logic [strq_pkg::TRACK_W-1:0] track;
    logic [strq_pkg::TAG_W-1:0]   tag;
    logic [strq_pkg::SEQ_W-1:0]   seq;
    logic [strq_pkg::COUNT_W-1:0] count;
  } queue_result_t;

  // shadow copy of the request queue, front at index 0
  logic [strq_pkg::TRACK_W-1:0] shadow_track [QUEUE_DEPTH];
  logic [strq_pkg::TAG_W-1:0]   shadow_tag   [QUEUE_DEPTH];
  logic [strq_pkg::SEQ_W-1:0]   shadow_seq   [QUEUE_DEPTH];
  int unsigned                  shadow_held;
  logic [strq_pkg::SEQ_W-1:0]   stamp_counter;

  queue_result_t      awaited_results[$];

  initial begin
    fail_count  = 0;
    results_due = 0;
    shadow_held = 0;
    stamp_counter = '0;
  end

  // slot for a new request: head match first, then end of first same-track run, else tail
  function automatic int unsigned slot_for(logic [strq_pkg::TRACK_W-1:0] trk,
                                           logic [strq_pkg::TRACK_W-1:0] head);
    if (shadow_held == 0 || trk == head) return 0;
    for (int unsigned i = 0; i < shadow_held; i++) begin
      if (shadow_track[i] == trk && (i + 1 == shadow_held || shadow_track[i + 1] != trk))
        return i + 1;
    end
    return shadow_held;
  endfunction

  function automatic queue_result_t apply_request(logic cmd,
                                                  logic [strq_pkg::TRACK_W-1:0] trk,
                                                  logic [strq_pkg::TAG_W-1:0] tag,
                                                  logic [strq_pkg::TRACK_W-1:0] head);
    queue_result_t r;
    int unsigned   slot;
    r = '0;
    r.status = strq_pkg::STAT_OK;
    if (cmd == strq_pkg::CMD_TAKE) begin
      if (shadow_held == 0) begin
        r.status = strq_pkg::STAT_EMPTY;
      end else begin
        r.track = shadow_track[0];
        r.tag   = shadow_tag[0];
        r.seq   = shadow_seq[0];
        for (int unsigned i = 0; i + 1 < shadow_held; i++) begin
          shadow_track[i] = shadow_track[i + 1];
          shadow_tag[i]   = shadow_tag[i + 1];
          shadow_seq[i]   = shadow_seq[i + 1];
        end
        shadow_held--;
      end
    end else if (shadow_held >= QUEUE_DEPTH) begin
      r.status = strq_pkg::STAT_FULL;
    end else begin
      stamp_counter = stamp_counter + 1'b1;
      slot = slot_for(trk, head);
      for (int unsigned i = shadow_held; i > slot; i--) begin
        shadow_track[i] = shadow_track[i - 1];
        shadow_tag[i]   = shadow_tag[i - 1];
        shadow_seq[i]   = shadow_seq[i - 1];
      end
      shadow_track[slot] = trk;
      shadow_tag[slot]   = tag;
      shadow_seq[slot]   = stamp_counter;
      shadow_held++;
      r.tag = tag;
      r.seq = stamp_counter;
    end
    r.count = strq_pkg::COUNT_W'(shadow_held);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [strq_pkg::SEQ_W-1:0] want,
                                        logic [strq_pkg::SEQ_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      shadow_held   = 0;
      stamp_counter = '0;
      awaited_results.delete();
    end else begin
      // a result is registered, so it always trails its own item; compare first
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d tag %0d seq %0d",
                   $time, out_status, out_tag, out_sequence);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", strq_pkg::SEQ_W'(want.status),
                        strq_pkg::SEQ_W'(out_status));
          compare_field("track", strq_pkg::SEQ_W'(want.track), strq_pkg::SEQ_W'(out_track));
          compare_field("tag", strq_pkg::SEQ_W'(want.tag), strq_pkg::SEQ_W'(out_tag));
          compare_field("sequence", want.seq, out_sequence);
          compare_field("queue_count", strq_pkg::SEQ_W'(want.count),
                        strq_pkg::SEQ_W'(out_queue_count));
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_request(in_command, in_req_track, in_req_tag,
                                                in_head_track));
    end
    results_due = awaited_results.size();
  end

endmodule

[tb/sv/testbench.sv]
// stimulus and verdict for the track-grouping request queue
module testbench;

  localparam int unsigned QUEUE_DEPTH = 32;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // command channel, all known from time zero
  logic                         start         = 1'b0;
  logic                         busy;
  logic                         in_command    = strq_pkg::CMD_ADD;
  logic [strq_pkg::TRACK_W-1:0] in_req_track  = '0;
  logic [strq_pkg::TAG_W-1:0]   in_req_tag    = '0;
  logic [strq_pkg::TRACK_W-1:0] in_head_track = '0;

  // result strobe
  logic                         out_valid;
  logic [1:0]                   out_status;
  logic [strq_pkg::TRACK_W-1:0] out_track;
  logic [strq_pkg::TAG_W-1:0]   out_tag;
  logic [strq_pkg::SEQ_W-1:0]   out_sequence;
  logic [strq_pkg::COUNT_W-1:0] out_queue_count;

  int fail_count;
  int results_due;

  // chance in percent that the sender pauses before an item
  int unsigned idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  same_track_request_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_req_track    (in_req_track),
    .in_req_tag      (in_req_tag),
    .in_head_track   (in_head_track),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_track       (out_track),
    .out_tag         (out_tag),
    .out_sequence    (out_sequence),
    .out_queue_count (out_queue_count)
  );

  strq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_req_track    (in_req_track),
    .in_req_tag      (in_req_tag),
    .in_head_track   (in_head_track),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_track       (out_track),
    .out_tag         (out_tag),
    .out_sequence    (out_sequence),
    .out_queue_count (out_queue_count),
    .fail_count      (fail_count),
    .results_due     (results_due)
  );

  // present one item and hold it until the block takes it
  // called at a rising edge; returns at the edge where the item was accepted
  task automatic issue_request(input strq_pkg::cmd_t cmd,
                               input logic [strq_pkg::TRACK_W-1:0] trk,
                               input logic [strq_pkg::TAG_W-1:0] tag,
                               input logic [strq_pkg::TRACK_W-1:0] head);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct)
      // mostly short pauses, now and then one long enough to outlast a list walk
      gap = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_req_track  <= trk;
    in_req_tag    <= tag;
    in_head_track <= head;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // tracks mostly from a small set so that groups form, the rest anywhere
  function automatic logic [strq_pkg::TRACK_W-1:0] pick_track();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return strq_pkg::TRACK_W'(3);
      4:       return strq_pkg::TRACK_W'(12'h800);
      5:       return strq_pkg::TRACK_W'(12'h7ff);
      default: return strq_pkg::TRACK_W'($urandom_range(2 ** strq_pkg::TRACK_W - 1));
    endcase
  endfunction

  // a random stretch: add_pct steers the fill level, pause_pct the sender gaps
  task automatic random_phase(input int unsigned items, input int unsigned add_pct,
                              input int unsigned pause_pct);
    logic [strq_pkg::TRACK_W-1:0] trk;
    logic [strq_pkg::TRACK_W-1:0] head;
    strq_pkg::cmd_t               cmd;
    idle_pct = pause_pct;
    for (int unsigned n = 0; n < items; n++) begin
      cmd  = ($urandom_range(99) < add_pct) ? strq_pkg::CMD_ADD : strq_pkg::CMD_TAKE;
      trk  = pick_track();
      // head equal to the request track about a quarter of the time
      head = ($urandom_range(3) == 0) ? trk : pick_track();
      issue_request(cmd, trk, strq_pkg::TAG_W'($urandom_range(2 ** strq_pkg::TAG_W - 1)),
                    head);
    end
  endtask

  initial begin
    // synchronous reset held from time zero, released at an edge
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no sender pauses
    idle_pct = 0;
    // take on empty queue
    issue_request(strq_pkg::CMD_TAKE, '0, '0, '0);
    // add into empty queue, lowest values
    issue_request(strq_pkg::CMD_ADD, '0, '0, '1);
    // highest values, no match so it lands at the tail
    issue_request(strq_pkg::CMD_ADD, '1, '1, '0);
    // joins the group of track 0 at the front
    issue_request(strq_pkg::CMD_ADD, '0, 16'h1234, 12'd5);
    // head match sends it to the front
    issue_request(strq_pkg::CMD_ADD, 12'd7, 16'h0001, 12'd7);
    // head match wins over an existing group
    issue_request(strq_pkg::CMD_ADD, '1, 16'hbeef, '1);
    // alternating bit patterns, both land at the tail
    issue_request(strq_pkg::CMD_ADD, 12'haaa, 16'ha5a5, 12'h555);
    issue_request(strq_pkg::CMD_ADD, 12'h555, 16'h5a5a, 12'haaa);
    // joins the run of its track, one place ahead of the tail
    issue_request(strq_pkg::CMD_ADD, 12'haaa, 16'h8000, 12'h123);
    // drain everything, then two more takes on the empty queue
    for (int i = 0; i < 9; i++)
      issue_request(strq_pkg::CMD_TAKE, strq_pkg::TRACK_W'($urandom),
                    strq_pkg::TAG_W'($urandom), strq_pkg::TRACK_W'($urandom));
    issue_request(strq_pkg::CMD_TAKE, '1, '1, '1);

    // random part: balanced, filling past full, draining past empty, with each pause mix
    random_phase(120, 50, 0);
    random_phase(120, 85, 45);
    random_phase(120, 20, 14);
    random_phase(130, 92, 0);
    random_phase(130, 50, 45);
    random_phase(130, 30, 14);
    start <= 1'b0;

    // wait out every result, then a full list walk more for stray strobes
    while (results_due != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("same_track_request_queue_top test passed");
    end else begin
      $display("same_track_request_queue_top test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("same_track_request_queue_top test failed");
    $finish;
  end

endmodule
